### hw/rtl/ima_enc_pkg.sv
// Shared types, tables and constants for the IMA ADPCM encoder.
package ima_enc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 7;
    localparam int STEP_W   = 15;
    localparam int CODE_W   = 4;

    localparam logic [INDEX_W-1:0] MAX_INDEX = 7'd88;

    localparam logic signed [SAMPLE_W+1:0] PRED_MAX = 18'sd32767;
    localparam logic signed [SAMPLE_W+1:0] PRED_MIN = -18'sd32768;

    // Per-item result of the quantizer, handed to the register stage
    typedef struct packed {
        logic [CODE_W-1:0]          code;
        logic signed [SAMPLE_W-1:0] pred_next;
        logic [INDEX_W-1:0]         index_next;
    } quant_result_t;

    // Step size for a step index; indexes beyond the table read as the last entry
    function automatic logic [STEP_W-1:0] step_lookup(input logic [INDEX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        unique case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // Index adjustment from the magnitude bits of a code (sign does not matter)
    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

### hw/rtl/ima_enc_quant.sv
// Quantizer and state update for one sample: code, next predictor, next index.
module ima_enc_quant
    import ima_enc_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [SAMPLE_W-1:0] pred,
    input  logic [INDEX_W-1:0]         step_index,
    output quant_result_t              result
);

    logic [INDEX_W-1:0]          idx;
    logic [STEP_W-1:0]           step;
    logic signed [SAMPLE_W:0]    diff;
    logic                        neg;
    logic [SAMPLE_W-1:0]         mag0;
    logic [SAMPLE_W-1:0]         mag1;
    logic [SAMPLE_W-1:0]         mag2;
    logic [SAMPLE_W-1:0]         probe0;
    logic [SAMPLE_W-1:0]         probe1;
    logic [SAMPLE_W-1:0]         probe2;
    logic                        b2;
    logic                        b1;
    logic                        b0;
    logic [SAMPLE_W-1:0]         dq;
    logic signed [SAMPLE_W+1:0]  pred_sum;
    logic signed [INDEX_W:0]     index_sum;

    // Clamp an out-of-range index and fetch the step
    assign idx  = (step_index > MAX_INDEX) ? MAX_INDEX : step_index;
    assign step = step_lookup(idx);

    // Signed difference and its magnitude
    assign diff = $signed({sample[SAMPLE_W-1], sample}) - $signed({pred[SAMPLE_W-1], pred});
    assign neg  = diff[SAMPLE_W];
    assign mag0 = neg ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

    // Successive compare-and-subtract against step, step/2, step/4
    assign probe0 = {1'b0, step};
    assign probe1 = {2'b00, step[STEP_W-1:1]};
    assign probe2 = {3'b000, step[STEP_W-1:2]};
    assign b2     = (mag0 >= probe0);
    assign mag1   = b2 ? (mag0 - probe0) : mag0;
    assign b1     = (mag1 >= probe1);
    assign mag2   = b1 ? (mag1 - probe1) : mag1;
    assign b0     = (mag2 >= probe2);

    // Dequantized difference
    assign dq = {4'b0000, step[STEP_W-1:3]}
              + (b2 ? probe0 : '0)
              + (b1 ? probe1 : '0)
              + (b0 ? probe2 : '0);

    // Predictor move with saturation
    assign pred_sum = neg ? ($signed({{2{pred[SAMPLE_W-1]}}, pred}) - $signed({2'b00, dq}))
                          : ($signed({{2{pred[SAMPLE_W-1]}}, pred}) + $signed({2'b00, dq}));

    // Index move with clamp to the table range
    assign index_sum = $signed({1'b0, idx}) + (INDEX_W+1)'(index_adjust({b2, b1, b0}));

    always_comb
    begin
        result.code = {neg, b2, b1, b0};

        if (pred_sum > PRED_MAX)
            result.pred_next = PRED_MAX[SAMPLE_W-1:0];
        else if (pred_sum < PRED_MIN)
            result.pred_next = PRED_MIN[SAMPLE_W-1:0];
        else
            result.pred_next = pred_sum[SAMPLE_W-1:0];

        if (index_sum[INDEX_W])
            result.index_next = '0;
        else if (index_sum[INDEX_W-1:0] > MAX_INDEX)
            result.index_next = MAX_INDEX;
        else
            result.index_next = index_sum[INDEX_W-1:0];
    end

endmodule

### hw/rtl/ima_adpcm_encoder_unit.sv
// Top level of the IMA ADPCM 4-bit encoder: input word register, state, result register.
//
// One signed 16-bit PCM word in, one 4-bit IMA ADPCM code out, at a sustained
// rate of one word per clock cycle while the output side is not stalled. A word
// is captured in an input register, quantized there against the predictor and
// step index, and its code is registered in the result register when the word
// advances; the result register then presents the code until the output side
// takes it. The rate is set by the predictor/step-index feedback loop, which
// closes through the quantizer. The result register holds a code while the
// output stalls, and the input register still takes one more word meanwhile.
// After reset the predictor and the step index are zero.
module ima_adpcm_encoder_unit
    import ima_enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pcm_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [3:0] adpcm_code, [7:4] zero
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic signed [SAMPLE_W-1:0]  in_sample_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [CODE_W-1:0]           out_code_reg;
    logic signed [SAMPLE_W-1:0]  pred_reg;
    logic [INDEX_W-1:0]          index_reg;
    logic                        advance;
    quant_result_t               quant;

    // Word moves from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    ima_enc_quant u_quant (
        .sample     (in_sample_reg),
        .pred       (pred_reg),
        .step_index (index_reg),
        .result     (quant)
    );

    // Handshake and encoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pred_reg      <= '0;
            index_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pred_reg  <= quant.pred_next;
                index_reg <= quant.index_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_sample_reg <= $signed(s_tdata);
        if (advance)
            out_code_reg <= quant.code;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_code_reg};

`ifndef ASSERT_OFF
    // Step index never leaves the table range
    assert property (@(posedge clk) disable iff (!rst_n) index_reg <= MAX_INDEX)
        else $error("step index beyond table range");

    // An empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // A word that advances always yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> m_tvalid)
        else $error("advanced word produced no result");

    // State only changes when a word is consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pred_reg) && $stable(index_reg))
        else $error("encoder state changed without a word");
`endif

endmodule
